@@ design/a85le_pkg.sv @@
// Shared types, character constants and the base-85 reciprocal for the ASCII85 line encoder.
// Used by a85le_front, a85le_queue, a85le_back and ascii85_line_encoder; depends on nothing.
package a85le_pkg;

  // Request codes carried on the input channel's tuser.
  typedef enum logic [1:0] {
    REQ_OPEN  = 2'd0,
    REQ_DATA  = 2'd1,
    REQ_CLOSE = 2'd2,
    REQ_NONE  = 2'd3
  } req_t;

  // Work kinds handed from the front to the back.
  typedef enum logic [1:0] {
    K_OPEN  = 2'd0,
    K_ZERO  = 2'd1,
    K_DATA  = 2'd2,
    K_CLOSE = 2'd3
  } kind_t;

  typedef enum logic [1:0] {
    BS_CHAR = 2'd0,
    BS_CR   = 2'd1,
    BS_LF   = 2'd2
  } bstate_t;

  localparam int NDIG = 5;

  // One queued job: its kind and, for a data word, the five printable digits,
  // most significant in element 0.
  typedef struct packed {
    kind_t                    kind;
    logic [NDIG-1:0][6:0]     digs;
  } entry_t;

  localparam logic [6:0] CH_BANG  = 7'h21;
  localparam logic [6:0] CH_Z     = 7'h7A;
  localparam logic [6:0] CH_LT    = 7'h3C;
  localparam logic [6:0] CH_TILDE = 7'h7E;
  localparam logic [6:0] CH_GT    = 7'h3E;
  localparam logic [6:0] CH_CR    = 7'h0D;
  localparam logic [6:0] CH_LF    = 7'h0A;

  localparam logic [7:0] WIDTH_RESET = 8'd78;
  localparam logic [7:0] WIDTH_MIN   = 8'd5;
  localparam logic [7:0] OPEN_POS    = 8'd2;

  // floor(x / 85) == (x * RECIP85) >> RECIP_SHIFT for every 32-bit x.
  localparam logic [31:0] RECIP85     = 32'd3233857729;
  localparam int          RECIP_SHIFT = 38;

endpackage

@@ design/ascii85_line_encoder.sv @@
// Top level of the line-wrapping ASCII85 encoder: width register, front end, queue, emitter.
// Depends on a85le_pkg, a85le_front, a85le_queue and a85le_back.
//
//   Port group   Direction  Payload
//   in_*         input      tdata[31:0] data_word; tuser[1:0] req_type
//   out_*        output     tdata[6:0] out_char, tdata[7] zero; tlast last
//   cfg_*        input      wdata[7:0] line_width, written when cfg_we is high
//
// A nonzero data word is accepted and then split into five digits by the divide-by-85 unit,
// one digit per cycle; the emitter sends one character per cycle unless the output stalls,
// up to seven per word. Open and close requests need no conversion and go to the queue from
// the front end's entry register, which takes no new request until its job is pushed.
// Reset (rst_n low, synchronous) empties the queue, clears the line position to zero
// and sets the line width to 78. A stalled output holds its character; the two-entry
// queue lets the front end keep converting meanwhile.
module ascii85_line_encoder (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [31:0] in_tdata,   // [31:0] data_word
  input  logic [1:0]  in_tuser,   // [1:0] req_type
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [7:0]  out_tdata,  // [6:0] out_char, [7] zero
  output logic        out_tlast,
  input  logic        cfg_we,
  input  logic [7:0]  cfg_wdata
);

  logic [7:0]         width_r, width_nxt;
  logic [7:0]         eff_width;
  logic               push_valid;
  logic               push_ready;
  a85le_pkg::entry_t  push_entry;
  logic               head_valid;
  logic               pop;
  a85le_pkg::entry_t  head;

  assign width_nxt = cfg_we ? cfg_wdata : width_r;
  // Narrow widths act as five so a word breaks its line at most once.
  assign eff_width = (width_r < a85le_pkg::WIDTH_MIN) ? a85le_pkg::WIDTH_MIN : width_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r <= a85le_pkg::WIDTH_RESET;
    end else begin
      width_r <= width_nxt;
    end
  end

  a85le_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_entry (push_entry)
  );

  a85le_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_entry (push_entry),
    .head_valid (head_valid),
    .pop        (pop),
    .head       (head)
  );

  a85le_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .eff_width  (eff_width),
    .head_valid (head_valid),
    .head       (head),
    .pop        (pop),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast)
  );

endmodule

@@ design/a85le_front.sv @@
// Front end: accepts requests, classifies them and converts nonzero data words to base-85
// digits. Depends on a85le_pkg; feeds a85le_queue.
module a85le_front (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_tvalid,
  output logic                in_tready,
  input  logic [31:0]         in_tdata,
  input  logic [1:0]          in_tuser,
  output logic                push_valid,
  input  logic                push_ready,
  output a85le_pkg::entry_t   push_entry
);

  logic                hold_r, hold_nxt;
  a85le_pkg::entry_t   entry_r, entry_nxt;
  logic [2:0]          cnt_r, cnt_nxt;
  logic [31:0]         val_r, val_nxt;

  logic [63:0]         prod;
  logic [31:0]         quot;
  logic [31:0]         quot85;
  logic [31:0]         rem;
  logic [2:0]          dig_idx;
  logic                fire_in;
  logic                pushed;

  assign prod    = {32'd0, val_r} * {32'd0, a85le_pkg::RECIP85};
  assign quot    = {6'd0, prod[63:a85le_pkg::RECIP_SHIFT]};
  assign quot85  = (quot << 6) + (quot << 4) + (quot << 2) + quot;
  assign rem     = val_r - quot85;
  assign dig_idx = cnt_r - 3'd1;

  assign push_valid = hold_r && (cnt_r == 3'd0);
  assign pushed     = push_valid && push_ready;
  assign in_tready  = !hold_r || pushed;
  assign fire_in    = in_tvalid && in_tready;
  assign push_entry = entry_r;

  always_comb begin
    hold_nxt  = hold_r;
    entry_nxt = entry_r;
    cnt_nxt   = cnt_r;
    val_nxt   = val_r;
    if (pushed) begin
      hold_nxt = 1'b0;
    end
    // Digits come out least significant first, filling the entry from the end.
    if (cnt_r != 3'd0) begin
      entry_nxt.digs[dig_idx] = rem[6:0] + a85le_pkg::CH_BANG;
      val_nxt                 = quot;
      cnt_nxt                 = cnt_r - 3'd1;
    end
    if (fire_in) begin
      unique case (a85le_pkg::req_t'(in_tuser))
        a85le_pkg::REQ_OPEN: begin
          hold_nxt       = 1'b1;
          entry_nxt.kind = a85le_pkg::K_OPEN;
          cnt_nxt        = 3'd0;
        end
        a85le_pkg::REQ_DATA: begin
          hold_nxt = 1'b1;
          if (in_tdata == 32'd0) begin
            entry_nxt.kind = a85le_pkg::K_ZERO;
            cnt_nxt        = 3'd0;
          end else begin
            entry_nxt.kind = a85le_pkg::K_DATA;
            cnt_nxt        = 3'(a85le_pkg::NDIG);
            val_nxt        = in_tdata;
          end
        end
        a85le_pkg::REQ_CLOSE: begin
          hold_nxt       = 1'b1;
          entry_nxt.kind = a85le_pkg::K_CLOSE;
          cnt_nxt        = 3'd0;
        end
        default: begin
          cnt_nxt = 3'd0;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hold_r <= 1'b0;
      cnt_r  <= 3'd0;
    end else begin
      hold_r <= hold_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    entry_r <= entry_nxt;
    val_r   <= val_nxt;
  end

endmodule

@@ design/a85le_queue.sv @@
// Two-entry queue of encoder jobs between the front end and the character emitter.
// Depends on a85le_pkg.
module a85le_queue (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                push_valid,
  output logic                push_ready,
  input  a85le_pkg::entry_t   push_entry,
  output logic                head_valid,
  input  logic                pop,
  output a85le_pkg::entry_t   head
);

  a85le_pkg::entry_t  mem_r [2];
  logic               wr_ptr_r, wr_ptr_nxt;
  logic               rd_ptr_r, rd_ptr_nxt;
  logic [1:0]         cnt_r, cnt_nxt;
  logic               do_push;
  logic               do_pop;

  assign push_ready = (cnt_r != 2'd2);
  assign head_valid = (cnt_r != 2'd0);
  assign head       = mem_r[rd_ptr_r];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop && head_valid;

  always_comb begin
    wr_ptr_nxt = do_push ? !wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = do_pop ? !rd_ptr_r : rd_ptr_r;
    cnt_nxt    = cnt_r + {1'b0, do_push} - {1'b0, do_pop};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_entry;
    end
  end

endmodule

@@ design/a85le_back.sv @@
// Back end: emits the queued job one character per cycle unless stalled, tracking the
// line position and inserting CR LF breaks. Depends on a85le_pkg; reads a85le_queue.
module a85le_back (
  input  logic                clk,
  input  logic                rst_n,
  input  logic [7:0]          eff_width,
  input  logic                head_valid,
  input  a85le_pkg::entry_t   head,
  output logic                pop,
  output logic                out_tvalid,
  input  logic                out_tready,
  output logic [7:0]          out_tdata,
  output logic                out_tlast
);

  a85le_pkg::bstate_t  state_r, state_nxt;
  logic [2:0]          idx_r, idx_nxt;
  logic                pre_r, pre_nxt;
  logic                end_r, end_nxt;
  logic [7:0]          pos_r, pos_nxt;
  logic                oval_r, oval_nxt;
  logic [6:0]          ochar_r, ochar_nxt;
  logic                olast_r, olast_nxt;

  logic                go;
  logic [2:0]          last_idx;
  logic                is_last;
  logic                wraps;
  logic [6:0]          ch;
  logic [8:0]          pos_inc;
  logic                pre_need;

  assign go       = head_valid && (!oval_r || out_tready);
  assign pos_inc  = {1'b0, pos_r} + 9'd1;
  assign pre_need = ({1'b0, pos_r} + 9'd2) > {1'b0, eff_width};
  assign is_last  = (idx_r == last_idx);
  assign wraps    = (head.kind == a85le_pkg::K_ZERO) || (head.kind == a85le_pkg::K_DATA);

  always_comb begin
    last_idx = 3'd0;
    ch       = a85le_pkg::CH_Z;
    unique case (head.kind)
      a85le_pkg::K_OPEN: begin
        last_idx = 3'd1;
        ch       = (idx_r == 3'd0) ? a85le_pkg::CH_LT : a85le_pkg::CH_TILDE;
      end
      a85le_pkg::K_ZERO: begin
        last_idx = 3'd0;
        ch       = a85le_pkg::CH_Z;
      end
      a85le_pkg::K_DATA: begin
        last_idx = 3'(a85le_pkg::NDIG - 1);
        ch       = head.digs[idx_r];
      end
      a85le_pkg::K_CLOSE: begin
        last_idx = 3'd3;
        case (idx_r)
          3'd0:    ch = a85le_pkg::CH_TILDE;
          3'd1:    ch = a85le_pkg::CH_GT;
          3'd2:    ch = a85le_pkg::CH_CR;
          default: ch = a85le_pkg::CH_LF;
        endcase
      end
      default: begin
        last_idx = 3'd0;
        ch       = a85le_pkg::CH_Z;
      end
    endcase
  end

  always_comb begin
    state_nxt = state_r;
    idx_nxt   = idx_r;
    pre_nxt   = pre_r;
    end_nxt   = end_r;
    pos_nxt   = pos_r;
    oval_nxt  = oval_r;
    ochar_nxt = ochar_r;
    olast_nxt = olast_r;
    pop       = 1'b0;
    if (oval_r && out_tready) begin
      oval_nxt = 1'b0;
    end
    if (go) begin
      oval_nxt = 1'b1;
      unique case (state_r)
        a85le_pkg::BS_CHAR: begin
          if ((head.kind == a85le_pkg::K_CLOSE) && (idx_r == 3'd0) && !pre_r && pre_need) begin
            // The end tag does not fit: break the line before it.
            ochar_nxt = a85le_pkg::CH_CR;
            olast_nxt = 1'b0;
            state_nxt = a85le_pkg::BS_LF;
            end_nxt   = 1'b0;
            pre_nxt   = 1'b1;
          end else if (wraps && (pos_inc >= {1'b0, eff_width})) begin
            ochar_nxt = ch;
            olast_nxt = 1'b0;
            pos_nxt   = 8'd0;
            state_nxt = a85le_pkg::BS_CR;
            end_nxt   = is_last;
            idx_nxt   = is_last ? 3'd0 : idx_r + 3'd1;
          end else begin
            ochar_nxt = ch;
            olast_nxt = is_last;
            if (wraps) begin
              pos_nxt = pos_inc[7:0];
            end else if (is_last) begin
              pos_nxt = (head.kind == a85le_pkg::K_OPEN) ? a85le_pkg::OPEN_POS : 8'd0;
            end
            if (is_last) begin
              pop     = 1'b1;
              idx_nxt = 3'd0;
              pre_nxt = 1'b0;
            end else begin
              idx_nxt = idx_r + 3'd1;
            end
          end
        end
        a85le_pkg::BS_CR: begin
          ochar_nxt = a85le_pkg::CH_CR;
          olast_nxt = 1'b0;
          state_nxt = a85le_pkg::BS_LF;
        end
        a85le_pkg::BS_LF: begin
          ochar_nxt = a85le_pkg::CH_LF;
          olast_nxt = end_r;
          state_nxt = a85le_pkg::BS_CHAR;
          if (end_r) begin
            pop     = 1'b1;
            idx_nxt = 3'd0;
            pre_nxt = 1'b0;
          end
        end
        default: begin
          state_nxt = a85le_pkg::BS_CHAR;
          oval_nxt  = oval_r && !out_tready;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= a85le_pkg::BS_CHAR;
      idx_r   <= 3'd0;
      pre_r   <= 1'b0;
      end_r   <= 1'b0;
      pos_r   <= 8'd0;
      oval_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      idx_r   <= idx_nxt;
      pre_r   <= pre_nxt;
      end_r   <= end_nxt;
      pos_r   <= pos_nxt;
      oval_r  <= oval_nxt;
    end
  end

  always_ff @(posedge clk) begin
    ochar_r <= ochar_nxt;
    olast_r <= olast_nxt;
  end

  assign out_tvalid = oval_r;
  assign out_tdata  = {1'b0, ochar_r};
  assign out_tlast  = olast_r;

endmodule
